// ===== hw/rtl/loc_pkg.sv =====
// shared types and constants for the lru object cache
// used by loc_cell, loc_chain and lru_object_cache; no dependencies
package loc_pkg;

    localparam int NUM_SLOTS_DEF     = 64;
    localparam int KEY_BITS_DEF      = 23;
    localparam int HANDLE_BITS_DEF   = 32;

    localparam int              CFG_BITS         = 24;
    localparam logic [CFG_BITS-1:0] TABLE_SIZE_RESET = 24'd8388608;

    typedef enum logic [1:0] {
        MODE_LOOKUP  = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_REPLACE = 2'd2,
        MODE_SPARE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_CACHED = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    // per-cell control: capture the key compare, or take the left neighbor's entry
    typedef struct packed {
        logic capture;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/loc_cell.sv =====
// one cell of the recency chain: holds one entry and its registered key match
// depends on loc_pkg
module loc_cell
    import loc_pkg::*;
#(
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cell_ctl_t              ctl,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic [KEY_BITS-1:0]    left_key,
    input  logic [HANDLE_BITS-1:0] left_value,
    input  logic                   left_valid,
    output logic [KEY_BITS-1:0]    key,
    output logic [HANDLE_BITS-1:0] value,
    output logic                   valid,
    output logic                   match,
    output logic [HANDLE_BITS-1:0] match_value
);

    logic [KEY_BITS-1:0]    key_reg;
    logic [KEY_BITS-1:0]    key_next;
    logic [HANDLE_BITS-1:0] value_reg;
    logic [HANDLE_BITS-1:0] value_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   match_reg;
    logic                   match_next;

    always_comb
    begin
        key_next   = ctl.shift ? left_key   : key_reg;
        value_next = ctl.shift ? left_value : value_reg;
        valid_next = ctl.shift ? left_valid : valid_reg;
        match_next = ctl.capture ? (valid_reg && (key_reg == req_key)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key         = key_reg;
    assign value       = value_reg;
    assign valid       = valid_reg;
    assign match       = match_reg;
    assign match_value = match_reg ? value_reg : '0;

endmodule

// ===== hw/rtl/loc_chain.sv =====
// row of loc_cell entries ordered from most to least recently used
// depends on loc_pkg and loc_cell
module loc_chain
    import loc_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
    localparam int IDX_BITS     = $clog2(NUM_SLOTS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   capture,
    input  logic                   shift_en,
    input  logic [IDX_BITS-1:0]    shift_limit,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic [KEY_BITS-1:0]    load_key,
    input  logic [HANDLE_BITS-1:0] load_value,
    output logic                   hit,
    output logic [IDX_BITS-1:0]    hit_index,
    output logic [HANDLE_BITS-1:0] hit_value,
    output logic [KEY_BITS-1:0]    tail_key,
    output logic [HANDLE_BITS-1:0] tail_value
);

    logic [KEY_BITS-1:0]    cell_key   [NUM_SLOTS];
    logic [HANDLE_BITS-1:0] cell_value [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   cell_valid;
    logic [NUM_SLOTS-1:0]   cell_match;
    logic [HANDLE_BITS-1:0] cell_mval  [NUM_SLOTS];

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        cell_ctl_t              ctl;
        logic [KEY_BITS-1:0]    lkey;
        logic [HANDLE_BITS-1:0] lvalue;
        logic                   lvalid;

        // cells up to the limit move one place toward the tail
        assign ctl.capture = capture;
        assign ctl.shift   = shift_en && (IDX_BITS'(i) <= shift_limit);

        if (i == 0)
        begin : g_head
            assign lkey   = load_key;
            assign lvalue = load_value;
            assign lvalid = 1'b1;
        end
        else
        begin : g_body
            assign lkey   = cell_key[i-1];
            assign lvalue = cell_value[i-1];
            assign lvalid = cell_valid[i-1];
        end

        loc_cell #(
            .KEY_BITS    (KEY_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .req_key     (req_key),
            .left_key    (lkey),
            .left_value  (lvalue),
            .left_valid  (lvalid),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .match       (cell_match[i]),
            .match_value (cell_mval[i])
        );
    end

    // keys are unique among valid cells, so at most one match bit is set
    always_comb
    begin
        hit_index = '0;
        hit_value = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            hit_index = hit_index | (cell_match[i] ? IDX_BITS'(i) : '0);
            hit_value = hit_value | cell_mval[i];
        end
    end

    assign hit        = |cell_match;
    assign tail_key   = cell_key[NUM_SLOTS-1];
    assign tail_value = cell_value[NUM_SLOTS-1];

endmodule

// ===== hw/rtl/lru_object_cache.sv =====
// lru object cache top level: request/response streams, table size register
// depends on loc_pkg and loc_chain
//
// usage:
//   requests enter on s_tvalid/s_tready. s_tuser carries mode (lookup, insert,
//   replace), s_tdata carries the object number and handle. every request gives
//   exactly one response on m_tvalid/m_tready with status in m_tuser.
//   the entries sit in a row of cells ordered most to least recently used; a
//   lookup or replace hit moves its entry to the head; an insert pushes every
//   entry one cell toward the tail, dropping the tail entry when full.
//   the request is registered at accept, the key compare in every cell is
//   registered after that, and then the match is decoded, the row shifted and
//   the response registered. a new request is not taken until the current one
//   is through; s_tready stays low through the compare and decode cycles.
//   s_tready is high only when no request is in progress. a response that is
//   not taken holds the next request in its final stage until the output
//   register frees; a new request may be taken while a response waits.
//   reset empties the cache and sets table_size to 8388608. cfg_we writes
//   table_size; the user must only use it while the block is idle (not enforced).
module lru_object_cache
    import loc_pkg::*;
#(
    parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF,
    parameter int HANDLE_BITS   = HANDLE_BITS_DEF,
    localparam int CNT_BITS     = $clog2(NUM_SLOTS + 1),
    localparam int IN_W         = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8,
    localparam int OUT_RAW      = HANDLE_BITS + 1 + KEY_BITS + HANDLE_BITS + CNT_BITS,
    localparam int OUT_W        = ((OUT_RAW + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // object_number, object_handle, zero pad
    input  logic [1:0]          s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // result_handle, release_valid,
                                           // release_object, release_handle,
                                           // occupancy, zero pad
    output logic [1:0]          m_tuser    // status
);

    localparam int IDX_BITS = $clog2(NUM_SLOTS);
    localparam int CMP_BITS = (KEY_BITS > CFG_BITS) ? KEY_BITS : CFG_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_RES  = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CFG_BITS-1:0]    table_size_reg;
    mode_t                  mode_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic                   in_range_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;

    logic                   m_tvalid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [HANDLE_BITS-1:0] result_reg;
    logic [HANDLE_BITS-1:0] result_next;
    logic                   rel_valid_reg;
    logic                   rel_valid_next;
    logic [KEY_BITS-1:0]    rel_key_reg;
    logic [KEY_BITS-1:0]    rel_key_next;
    logic [HANDLE_BITS-1:0] rel_handle_reg;
    logic [HANDLE_BITS-1:0] rel_handle_next;

    logic                   accept;
    logic                   out_free;
    logic                   fire;
    logic                   full;
    logic                   do_insert;
    logic                   do_promote;
    logic                   shift_en;
    logic [IDX_BITS-1:0]    shift_limit;
    logic [HANDLE_BITS-1:0] load_value;

    logic                   hit;
    logic [IDX_BITS-1:0]    hit_index;
    logic [HANDLE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]    tail_key;
    logic [HANDLE_BITS-1:0] tail_value;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == S_RES) && out_free;
    assign full     = (count_reg == CNT_BITS'(NUM_SLOTS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_CMP;
            S_CMP:   state_next = S_RES;
            S_RES:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // decide the operation from the registered matches
    always_comb
    begin
        status_next     = ST_OK;
        result_next     = '0;
        rel_valid_next  = 1'b0;
        rel_key_next    = '0;
        rel_handle_next = '0;
        do_insert       = 1'b0;
        do_promote      = 1'b0;
        load_value      = handle_reg;
        shift_limit     = '0;
        count_next      = count_reg;

        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (hit)
                    status_next = ST_CACHED;
                else if (!in_range_reg)
                    status_next = ST_RANGE;
                else
                    do_insert = 1'b1;
            end
            MODE_REPLACE:
            begin
                // a cached entry is overwritten without a range check
                if (hit)
                begin
                    rel_valid_next  = 1'b1;
                    rel_key_next    = key_reg;
                    rel_handle_next = hit_value;
                    do_promote      = 1'b1;
                end
                else if (!in_range_reg)
                    status_next = ST_RANGE;
                else
                    do_insert = 1'b1;
            end
            default:
            begin
                if (!in_range_reg)
                    status_next = ST_RANGE;
                else if (!hit)
                    status_next = ST_MISS;
                else
                begin
                    result_next = hit_value;
                    load_value  = hit_value;
                    do_promote  = 1'b1;
                end
            end
        endcase

        if (do_promote)
            shift_limit = hit_index;

        if (do_insert)
        begin
            if (full)
            begin
                shift_limit     = IDX_BITS'(NUM_SLOTS - 1);
                rel_valid_next  = 1'b1;
                rel_key_next    = tail_key;
                rel_handle_next = tail_value;
            end
            else
            begin
                shift_limit = count_reg[IDX_BITS-1:0];
                count_next  = count_reg + CNT_BITS'(1);
            end
        end
    end

    assign shift_en = fire && (do_insert || do_promote);

    loc_chain #(
        .NUM_SLOTS     (NUM_SLOTS),
        .KEY_BITS      (KEY_BITS),
        .HANDLE_BITS   (HANDLE_BITS)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture     (state_reg == S_CMP),
        .shift_en    (shift_en),
        .shift_limit (shift_limit),
        .req_key     (key_reg),
        .load_key    (key_reg),
        .load_value  (load_value),
        .hit         (hit),
        .hit_index   (hit_index),
        .hit_value   (hit_value),
        .tail_key    (tail_key),
        .tail_value  (tail_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= TABLE_SIZE_RESET;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                table_size_reg <= cfg_wdata;
            if (fire)
                count_reg <= count_next;
            if (fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode_t'(s_tuser);
            key_reg    <= s_tdata[KEY_BITS-1:0];
            handle_reg <= s_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];
        end
        if (state_reg == S_CMP)
            in_range_reg <= CMP_BITS'(key_reg) < CMP_BITS'(table_size_reg);
        if (fire)
        begin
            status_reg     <= status_next;
            result_reg     <= result_next;
            rel_valid_reg  <= rel_valid_next;
            rel_key_reg    <= rel_key_next;
            rel_handle_reg <= rel_handle_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({count_reg, rel_handle_reg, rel_key_reg,
                              rel_valid_reg, result_reg});

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for lru_object_cache: directed and random request traffic
// with a shadow model of the cache that predicts every response
// depends on loc_pkg and the lru_object_cache rtl
module testbench;
    import loc_pkg::*;

    localparam int ENTRIES = NUM_SLOTS_DEF;
    localparam logic [22:0] KEY_MAX = 23'h7FFFFF;

    typedef struct {
        status_t     status;
        logic [31:0] result_handle;
        logic        release_valid;
        logic [22:0] release_object;
        logic [31:0] release_handle;
        logic [6:0]  occupancy;
    } cache_reply_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // object_number, object_handle, zero pad
    logic [1:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // result_handle, release_valid, release_object,
                                 // release_handle, occupancy, zero pad
    logic [1:0]  m_tuser;        // status

    // shadow copy of the cache
    logic [22:0] shadow_key [ENTRIES];
    logic [31:0] shadow_handle [ENTRIES];
    bit          shadow_used [ENTRIES];
    int unsigned shadow_age [ENTRIES];
    int unsigned shadow_count;
    logic [23:0] shadow_table_size;

    cache_reply_t predicted_replies [$];
    int error_count;
    int request_count;
    int reply_count;
    int release_count;
    int status_seen [4];
    int table_size_writes;
    int send_idle_pct;
    int stall_pct;
    int pause_cycles;

    lru_object_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("lru_object_cache regression: fail");
        $finish;
    end

    function automatic void shadow_reset();
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_used[i] = 1'b0;
            shadow_age[i] = 0;
            shadow_key[i] = '0;
            shadow_handle[i] = '0;
        end
        shadow_count = 0;
        shadow_table_size = TABLE_SIZE_RESET;
    endfunction

    // move an entry to the head, aging everything that was newer
    function automatic void promote_slot(int slot);
        int unsigned age;
        age = shadow_age[slot];
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_used[i] && shadow_age[i] < age)
                shadow_age[i]++;
        shadow_age[slot] = 0;
    endfunction

    function automatic void admit_entry(logic [22:0] key, logic [31:0] handle,
                                        inout cache_reply_t reply);
        int victim;
        int free_slot;
        victim = -1;
        free_slot = -1;
        if (shadow_count >= ENTRIES)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_used[i] && (victim < 0 || shadow_age[i] > shadow_age[victim]))
                    victim = i;
            if (victim >= 0)
            begin
                reply.release_valid = 1'b1;
                reply.release_object = shadow_key[victim];
                reply.release_handle = shadow_handle[victim];
                shadow_used[victim] = 1'b0;
            end
            shadow_count = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_used[i])
                    shadow_count++;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!shadow_used[i])
            begin
                if (free_slot < 0)
                    free_slot = i;
            end
            else
                shadow_age[i]++;
        end
        if (free_slot < 0)
            return;
        shadow_key[free_slot] = key;
        shadow_handle[free_slot] = handle;
        shadow_used[free_slot] = 1'b1;
        shadow_age[free_slot] = 0;
        shadow_count++;
    endfunction

    function automatic cache_reply_t predict_access(mode_t mode, logic [22:0] key,
                                                    logic [31:0] handle);
        cache_reply_t reply;
        int hit_slot;
        logic in_range;
        reply.status = ST_OK;
        reply.result_handle = '0;
        reply.release_valid = 1'b0;
        reply.release_object = '0;
        reply.release_handle = '0;
        in_range = {1'b0, key} < shadow_table_size;
        hit_slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_slot < 0 && shadow_used[i] && shadow_key[i] == key)
                hit_slot = i;
        case (mode)
            MODE_INSERT:
            begin
                // an already cached number wins over the range check
                if (hit_slot >= 0)
                    reply.status = ST_CACHED;
                else if (!in_range)
                    reply.status = ST_RANGE;
                else
                    admit_entry(key, handle, reply);
            end
            MODE_REPLACE:
            begin
                // a cached entry is overwritten with no range check
                if (hit_slot >= 0)
                begin
                    reply.release_valid = 1'b1;
                    reply.release_object = shadow_key[hit_slot];
                    reply.release_handle = shadow_handle[hit_slot];
                    shadow_handle[hit_slot] = handle;
                    promote_slot(hit_slot);
                end
                else if (!in_range)
                    reply.status = ST_RANGE;
                else
                    admit_entry(key, handle, reply);
            end
            default:
            begin
                // spare mode is a lookup
                if (!in_range)
                    reply.status = ST_RANGE;
                else if (hit_slot < 0)
                    reply.status = ST_MISS;
                else
                begin
                    reply.result_handle = shadow_handle[hit_slot];
                    promote_slot(hit_slot);
                end
            end
        endcase
        reply.occupancy = shadow_count[6:0];
        return reply;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // receiver: random stalls, or a long counted hold-off when one is asked for
    always @(posedge clk)
    begin
        if (pause_cycles > 0)
        begin
            m_tready <= 1'b0;
            pause_cycles--;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cache_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            reply_count++;
            status_seen[m_tuser]++;
            if (m_tdata[32])
                release_count++;
            if (predicted_replies.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = predicted_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, want.status));
                if (m_tdata[31:0] !== want.result_handle)
                    report_mismatch($sformatf("result_handle got %h want %h",
                                              m_tdata[31:0], want.result_handle));
                if (m_tdata[32] !== want.release_valid)
                    report_mismatch($sformatf("release_valid got %b want %b",
                                              m_tdata[32], want.release_valid));
                if (m_tdata[55:33] !== want.release_object)
                    report_mismatch($sformatf("release_object got %h want %h",
                                              m_tdata[55:33], want.release_object));
                if (m_tdata[87:56] !== want.release_handle)
                    report_mismatch($sformatf("release_handle got %h want %h",
                                              m_tdata[87:56], want.release_handle));
                if (m_tdata[94:88] !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              m_tdata[94:88], want.occupancy));
            end
        end
    end

    task automatic send_request(mode_t mode, logic [22:0] key, logic [31:0] handle);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, handle, key};
        s_tuser <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        predicted_replies.push_back(predict_access(mode, key, handle));
        request_count++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(logic [23:0] value);
        wait_for_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_table_size = value;
        table_size_writes++;
    endtask

    function automatic mode_t pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return MODE_LOOKUP;
        else if (r < 65)
            return MODE_INSERT;
        else if (r < 93)
            return MODE_REPLACE;
        return MODE_SPARE;
    endfunction

    // mostly a small key pool so that hits and evictions are frequent
    function automatic logic [22:0] pick_key(int pool_max);
        int r;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(99);
        if (r < 75)
            return 23'($urandom_range(pool_max));
        if (r < 85)
        begin
            lo = (shadow_table_size > 2) ? shadow_table_size - 2 : 0;
            hi = shadow_table_size + 1;
            if (hi > KEY_MAX)
                hi = KEY_MAX;
            if (lo > hi)
                lo = hi;
            return 23'($urandom_range(hi, lo));
        end
        return 23'($urandom());
    endfunction

    task automatic run_traffic(int count, int pool_max, int sender_idle, int stall);
        send_idle_pct = sender_idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_request(pick_mode(), pick_key(pool_max), $urandom());
    endtask

    task automatic test_basic_ops();
        send_request(MODE_LOOKUP, 23'd5, 32'h0);            // miss on empty cache
        send_request(MODE_INSERT, 23'd0, 32'h0);
        send_request(MODE_INSERT, KEY_MAX, 32'hFFFFFFFF);
        send_request(MODE_LOOKUP, 23'd0, 32'h0);
        send_request(MODE_LOOKUP, KEY_MAX, 32'h0);
        send_request(MODE_INSERT, 23'd0, 32'h11111111);     // already cached
        send_request(MODE_REPLACE, 23'd0, 32'h12345678);    // old handle released
        send_request(MODE_REPLACE, 23'd77, 32'hCAFE0077);   // absent: plain insert
        send_request(MODE_SPARE, 23'd77, 32'h0);
        send_request(MODE_LOOKUP, 23'd78, 32'h0);
    endtask

    task automatic test_range_checks();
        write_table_size(24'd0);
        send_request(MODE_LOOKUP, 23'd0, 32'h0);
        send_request(MODE_INSERT, 23'd0, 32'h0);            // cached beats range
        send_request(MODE_INSERT, 23'd5, 32'h55555555);
        send_request(MODE_REPLACE, KEY_MAX, 32'hA5A5A5A5);  // no range check on a hit
        send_request(MODE_REPLACE, 23'd6, 32'h5A5A5A5A);
        send_request(MODE_SPARE, 23'd9, 32'h0);
    endtask

    task automatic test_fill_and_evict();
        write_table_size(TABLE_SIZE_RESET);
        for (int i = 0; i < ENTRIES + 6; i++)
            send_request(MODE_INSERT, 23'(1000 + i), $urandom());
        send_request(MODE_LOOKUP, 23'd0, 32'h0);
        send_request(MODE_LOOKUP, 23'(1000 + ENTRIES + 5), 32'h0);
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        send_idle_pct = 0;
        stall_pct = 0;
        pause_cycles = 300;
        for (int i = 0; i < 24; i++)
            send_request(pick_mode(), pick_key(20), $urandom());
    endtask

    task automatic test_random_traffic();
        write_table_size(TABLE_SIZE_RESET);
        run_traffic(260, 96, 0, 0);
        write_table_size(24'd60);
        run_traffic(220, 96, 66, 0);
        write_table_size(24'd1);
        run_traffic(160, 8, 0, 66);
        write_table_size(24'd8388607);
        run_traffic(220, 96, 12, 12);
        write_table_size(24'($urandom_range(24'd8388608)));
        run_traffic(120, 120, 0, 0);
        write_table_size(24'd40);
        run_traffic(150, 48, 66, 66);
    endtask

    initial
    begin
        shadow_reset();
        error_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        pause_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_range_checks();
        test_fill_and_evict();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        repeat (6) @(posedge clk);
        $display("covered %0d requests over %0d table_size writes, %0d handles released",
                 request_count, table_size_writes, release_count);
        $display("responses: %0d ok, %0d miss, %0d already cached, %0d out of range",
                 status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_CACHED],
                 status_seen[ST_RANGE]);
        if (error_count == 0 && predicted_replies.size() == 0 && reply_count == request_count)
            $display("lru_object_cache regression: pass");
        else
            $display("lru_object_cache regression: fail");
        $finish;
    end

endmodule
